// ----- rtl/core/dnsenc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsenc_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnsenc_pkg;

	localparam int STORE_DEPTH = 63;
	localparam int PTR_W       = 6;
	localparam int ADDR_W      = 2;

	localparam logic [7:0]        SEP_RESET = 8'd46;
	localparam logic [ADDR_W-1:0] ADDR_SEP  = 2'd0;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_END  = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LEN,
		S_CHR,
		S_ONE
	} state_t;

	typedef struct packed {
		logic store_char;
		logic set_err;
		logic start_emit;
		logic at_end;
		logic load_len;
		logic load_chr;
		logic load_one;
		logic clear_len;
		logic clear_name;
	} cmd_t;

	typedef struct packed {
		logic is_sep;
		logic len_zero;
		logic len_full;
		logic err_seen;
		logic out_load;
		logic last_chr;
	} stat_t;

endpackage

// ----- rtl/core/dnsenc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsenc_ctrl
// Sequencer: takes requests, starts label emission and steps it out.
// ----------------------------------------------------------------------------
module dnsenc_ctrl
	import dnsenc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  logic  req_type,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_type == REQ_END) begin
						if (stat.err_seen || stat.len_zero) begin
							state_d = S_ONE;
						end else begin
							cmd.start_emit = 1'b1;
							cmd.at_end     = 1'b1;
							state_d        = S_LEN;
						end
					end else if (!stat.err_seen) begin
						if (stat.is_sep) begin
							if (stat.len_zero) begin
								cmd.set_err = 1'b1;
							end else begin
								cmd.start_emit = 1'b1;
								state_d        = S_LEN;
							end
						end else if (stat.len_full) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.store_char = 1'b1;
						end
					end
				end
			end
			S_LEN: begin
				if (stat.out_load) begin
					cmd.load_len = 1'b1;
					state_d      = S_CHR;
				end
			end
			S_CHR: begin
				if (stat.out_load) begin
					cmd.load_chr = 1'b1;
					if (stat.last_chr) begin
						cmd.clear_len = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_ONE: begin
				if (stat.out_load) begin
					cmd.load_one   = 1'b1;
					cmd.clear_name = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/dnsenc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsenc_dp
// Datapath: label store, length and read pointer, output register.
// ----------------------------------------------------------------------------
module dnsenc_dp
	import dnsenc_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] sep_char,
	input  logic [7:0] char_value,
	input  cmd_t       cmd,
	output stat_t      stat,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] wire_byte,
	output logic       terminator_follows,
	output logic       last,
	output logic       error
);

	localparam int LIMIT = (MAX_LABEL > STORE_DEPTH) ? STORE_DEPTH : MAX_LABEL;
	localparam logic [PTR_W-1:0] LIMIT_V = PTR_W'(LIMIT);

	logic [7:0]       store_q [STORE_DEPTH];
	logic [7:0]       rd_q;
	logic [PTR_W-1:0] len_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_d;
	logic             err_q;
	logic             at_end_q;
	logic             last_chr;
	logic             out_load;

	assign last_chr = (ptr_q == (len_q - PTR_W'(1)));
	assign out_load = !rsp_valid || rsp_ready;

	assign stat.is_sep   = (char_value == sep_char);
	assign stat.len_zero = (len_q == '0);
	assign stat.len_full = (len_q >= LIMIT_V);
	assign stat.err_seen = err_q;
	assign stat.out_load = out_load;
	assign stat.last_chr = last_chr;

	always_comb begin
		ptr_d = ptr_q;
		if (cmd.start_emit) begin
			ptr_d = '0;
		end else if (cmd.load_chr) begin
			ptr_d = last_chr ? '0 : ptr_q + PTR_W'(1);
		end
	end

	// store read is re-done each cycle at the next pointer value
	always_ff @(posedge clk) begin
		if (cmd.store_char) begin
			store_q[len_q] <= char_value;
		end
		rd_q <= store_q[ptr_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ptr_q    <= '0;
			err_q    <= 1'b0;
			at_end_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.store_char) begin
				len_q <= len_q + PTR_W'(1);
			end else if (cmd.clear_len || cmd.clear_name) begin
				len_q <= '0;
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end else if (cmd.clear_name) begin
				err_q <= 1'b0;
			end
			if (cmd.start_emit) begin
				at_end_q <= cmd.at_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.load_len || cmd.load_chr || cmd.load_one) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			wire_byte          <= {{(8-PTR_W){1'b0}}, len_q};
			terminator_follows <= 1'b0;
			last               <= 1'b0;
			error              <= 1'b0;
		end else if (cmd.load_chr) begin
			wire_byte          <= rd_q;
			terminator_follows <= at_end_q && last_chr;
			last               <= at_end_q && last_chr;
			error              <= 1'b0;
		end else if (cmd.load_one) begin
			wire_byte          <= 8'd0;
			terminator_follows <= 1'b0;
			last               <= 1'b1;
			error              <= err_q;
		end
	end

endmodule

// ----- rtl/core/dns_name_label_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted domain name in, one character per request, DNS wire format out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid/req_ready   | req_type, char_value
//  rsp     | rsp_valid/rsp_ready   | wire_byte, terminator_follows, last, error
//  cfg     | APB psel/penable/...  | separator_char at byte address 0
//
//  A plain character is taken in the idle state. A separator or end request that
//  writes out a label holds req_ready low while the length byte and then each
//  character read from the store are sent, and through any rsp stall. Other end
//  requests hold it low for a lone zero byte. Reset clears length, error flag
//  and state; the label store is not cleared. Output is a single register.
// ----------------------------------------------------------------------------
module dns_name_label_encoder
	import dnsenc_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              req_type,
	input  logic [7:0]        char_value,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [7:0]        wire_byte,
	output logic              terminator_follows,
	output logic              last,
	output logic              error,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [7:0] sep_q;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_SEP) ? {24'd0, sep_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_SEP)) begin
			sep_q <= pwdata[7:0];
		end
	end

	dnsenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.stat      (stat),
		.cmd       (cmd)
	);

	dnsenc_dp #(
		.MAX_LABEL (MAX_LABEL)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.sep_char           (sep_q),
		.char_value         (char_value),
		.cmd                (cmd),
		.stat               (stat),
		.rsp_valid          (rsp_valid),
		.rsp_ready          (rsp_ready),
		.wire_byte          (wire_byte),
		.terminator_follows (terminator_follows),
		.last               (last),
		.error              (error)
	);

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error |-> last && !terminator_follows && (wire_byte == 8'd0))
		else $error("error result is not a lone final zero byte");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && terminator_follows |-> last)
		else $error("terminator flag on a non-final result");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable({wire_byte, terminator_follows, last, error}))
		else $error("stalled response dropped or changed");

endmodule
